// ----- rtl/rau_pkg.sv -----
// Package for the rational arithmetic unit: widths, opcodes, controller types.
`timescale 1ns / 1ps
package rau_pkg;
    localparam int OPERAND_WIDTH = 16;
    localparam int RES_NUM_W = 32;
    localparam int RES_DEN_W = 31;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4,
        OP_INC = 3'd5,
        OP_DEC = 3'd6,
        OP_NOP = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FORM,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic form;
        logic gcd_init;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic div_sel_den;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic reduce;
        logic gcd_done;
        logic div_done;
    } t_status;
endpackage

// ----- rtl/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit: stream ports, controller, datapath.
`timescale 1ns / 1ps
// One item at a time. Add, subtract, multiply, divide and compare pass
// through idle, multiply, form, gcd, the numerator and denominator divisions
// and done; the gcd state runs a bit-serial binary gcd, and the two divisions
// by the common factor are one-bit-a-cycle. Increment, decrement and the
// unused code skip the gcd and the divisions. The result sits in an output
// register; a held-off result stalls the controller in its last state, and
// the next beat is taken once it is back in idle.
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // a_num, a_den, b_num, b_den from the lowest bit up; zero fill to bytes
    input  logic [((4*OPERAND_WIDTH-2+7)/8)*8-1:0] s_axis_tdata,
    // req_type
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // res_num [31:0], res_den [62:32], cmp_sign [64:63]; zero fill to 72
    output logic [71:0] m_axis_tdata
);
    localparam int W = OPERAND_WIDTH;

    rau_pkg::t_cmd    w_cmd;
    rau_pkg::t_status w_status;
    logic             w_busy, w_done;
    logic             r_ovalid;
    logic [31:0]      w_num;
    logic [30:0]      w_den;
    logic [1:0]       w_cmp;

    assign s_axis_tready = !w_busy;

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (s_axis_tvalid && s_axis_tready),
        .i_out_free (!r_ovalid || m_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy),
        .o_done     (w_done)
    );

    rau_datapath #(.OPERAND_WIDTH(W)) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_req_type (s_axis_tuser),
        .i_a_num    (s_axis_tdata[W-1:0]),
        .i_a_den    (s_axis_tdata[2*W-2:W]),
        .i_b_num    (s_axis_tdata[3*W-2:2*W-1]),
        .i_b_den    (s_axis_tdata[4*W-3:3*W-1]),
        .o_res_num  (w_num),
        .o_res_den  (w_den),
        .o_cmp_sign (w_cmp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_done) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {7'd0, w_cmp, w_den, w_num};
endmodule

// ----- rtl/rau_datapath.sv -----
// Datapath: cross products, binary gcd, restoring division and result register.
`timescale 1ns / 1ps
module rau_datapath #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
    input  logic                                i_clk,
    input  rau_pkg::t_cmd                       i_cmd,
    output rau_pkg::t_status                    o_status,
    input  logic [2:0]                          i_req_type,
    input  logic signed [OPERAND_WIDTH-1:0]     i_a_num,
    input  logic [OPERAND_WIDTH-2:0]            i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]     i_b_num,
    input  logic [OPERAND_WIDTH-2:0]            i_b_den,
    output logic [rau_pkg::RES_NUM_W-1:0]       o_res_num,
    output logic [rau_pkg::RES_DEN_W-1:0]       o_res_den,
    output logic [1:0]                          o_cmp_sign
);
    localparam int W = OPERAND_WIDTH;
    localparam int PW = 2 * W + 1;      // signed sum of products
    localparam int MW = 2 * W;          // magnitudes
    localparam int SW = $clog2(MW + 1);

    logic [2:0]            r_op;
    logic signed [W-1:0]   r_an, r_bn;
    logic signed [W:0]     r_ad, r_bd;
    logic signed [2*W:0]   r_p0, r_p1, r_p2;
    logic                  r_neg, r_den_pos;
    logic [MW-1:0]         r_un, r_ud, r_gx, r_gy, r_f;
    logic [SW-1:0]         r_k;
    logic [MW-1:0]         r_q, r_rem, r_dvd;
    logic [SW-1:0]         r_cnt;
    logic [MW-1:0]         r_qn;
    logic [rau_pkg::RES_NUM_W-1:0] r_res_num;
    logic [rau_pkg::RES_DEN_W-1:0] r_res_den;
    logic [1:0]            r_cmp;
    logic                  r_zero;

    logic signed [PW-1:0]  w_n, w_d;
    logic [MW:0]           w_trial;
    logic [MW-1:0]         w_rem_sh;
    logic [MW-1:0]         w_diff;

    always_comb begin
        case (rau_pkg::t_op'(r_op))
            rau_pkg::OP_ADD: begin
                w_n = PW'(r_p0) + PW'(r_p1);
                w_d = PW'(r_p2);
            end
            rau_pkg::OP_SUB, rau_pkg::OP_CMP: begin
                w_n = PW'(r_p0) - PW'(r_p1);
                w_d = PW'(r_p2);
            end
            rau_pkg::OP_MUL: begin
                w_n = PW'(r_p1);
                w_d = PW'(r_p2);
            end
            rau_pkg::OP_DIV: begin
                w_n = PW'(r_p0);
                w_d = PW'(r_p1);
            end
            default: begin
                w_n = '0;
                w_d = '0;
            end
        endcase
    end

    assign w_rem_sh = {r_rem[MW-2:0], r_dvd[MW-1]};
    assign w_trial = {1'b0, w_rem_sh} - {1'b0, r_f};
    assign w_diff = (r_gx > r_gy) ? (r_gx - r_gy) : (r_gy - r_gx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_req_type;
            r_an <= i_a_num;
            r_bn <= i_b_num;
            r_ad <= {2'b00, i_a_den};
            r_bd <= {2'b00, i_b_den};
        end
        // multiplies are registered; MUL/DIV pick which products they need
        if (i_cmd.load) begin
            r_p0 <= '0;
        end else if (!i_cmd.form && !i_cmd.gcd_step && !i_cmd.div_step) begin
            if (rau_pkg::t_op'(r_op) == rau_pkg::OP_DIV) begin
                r_p0 <= (2*W+1)'(r_an) * (2*W+1)'(r_bd);
                r_p1 <= (2*W+1)'(r_ad) * (2*W+1)'(r_bn);
            end else if (rau_pkg::t_op'(r_op) == rau_pkg::OP_MUL) begin
                r_p1 <= (2*W+1)'(r_an) * (2*W+1)'(r_bn);
                r_p2 <= (2*W+1)'(r_ad) * (2*W+1)'(r_bd);
            end else begin
                r_p0 <= (2*W+1)'(r_an) * (2*W+1)'(r_bd);
                r_p1 <= (2*W+1)'(r_ad) * (2*W+1)'(r_bn);
                r_p2 <= (2*W+1)'(r_ad) * (2*W+1)'(r_bd);
            end
        end
        if (i_cmd.form) begin
            r_un <= MW'(w_n[PW-1] ? -w_n : w_n);
            r_ud <= MW'(w_d[PW-1] ? -w_d : w_d);
            r_neg <= w_n[PW-1];
            r_den_pos <= !w_d[PW-1] && (w_d != '0);
            r_zero <= (w_n == '0) || (w_d == '0);
        end
        // binary gcd: strip common twos, then subtract and shift
        if (i_cmd.gcd_init) begin
            r_gx <= r_un;
            r_gy <= r_ud;
            r_k <= '0;
        end else if (i_cmd.gcd_step) begin
            if (!r_gx[0] && !r_gy[0]) begin
                r_gx <= r_gx >> 1;
                r_gy <= r_gy >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_gx[0]) begin
                r_gx <= r_gx >> 1;
            end else if (!r_gy[0]) begin
                r_gy <= r_gy >> 1;
            end else begin
                r_gx <= (r_gx < r_gy) ? r_gx : r_gy;
                r_gy <= w_diff;
            end
        end
        // factor is captured on the cycle the first division is set up
        if (i_cmd.gcd_init) begin
            r_f <= '0;
        end else if (o_status.gcd_done && !i_cmd.div_step) begin
            r_f <= r_zero ? MW'(1) : (r_gx << r_k);
        end
        if (i_cmd.div_init) begin
            r_dvd <= i_cmd.div_sel_den ? r_ud : r_un;
            r_rem <= '0;
            r_q <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            r_cnt <= r_cnt + 1'b1;
            if (!w_trial[MW]) begin
                r_rem <= w_trial[MW-1:0];
                r_q <= {r_q[MW-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_q <= {r_q[MW-2:0], 1'b0};
            end
        end
        if (i_cmd.div_init && i_cmd.div_sel_den) begin
            r_qn <= r_q;
        end
        if (i_cmd.finish) begin
            case (rau_pkg::t_op'(r_op))
                rau_pkg::OP_INC: begin
                    r_res_num <= 32'(signed'(r_an)) + 32'(r_ad);
                    r_res_den <= 31'(r_ad);
                    r_cmp <= '0;
                end
                rau_pkg::OP_DEC: begin
                    r_res_num <= 32'(signed'(r_an)) - 32'(r_ad);
                    r_res_den <= 31'(r_ad);
                    r_cmp <= '0;
                end
                rau_pkg::OP_CMP: begin
                    r_res_num <= '0;
                    r_res_den <= '0;
                    r_cmp <= (r_qn == '0) ? 2'b00 : ((r_neg ^ !r_den_pos) ? 2'b11 : 2'b01);
                end
                rau_pkg::OP_NOP: begin
                    r_res_num <= '0;
                    r_res_den <= '0;
                    r_cmp <= '0;
                end
                default: begin
                    r_res_num <= 32'((r_neg ^ !r_den_pos) ? -{1'b0, r_qn} : {1'b0, r_qn});
                    r_res_den <= 31'(r_q);
                    r_cmp <= '0;
                end
            endcase
        end
    end

    always_comb begin
        o_status.reduce = (rau_pkg::t_op'(r_op) != rau_pkg::OP_INC) &&
                          (rau_pkg::t_op'(r_op) != rau_pkg::OP_DEC) &&
                          (rau_pkg::t_op'(r_op) != rau_pkg::OP_NOP);
        o_status.gcd_done = r_zero || (r_gy == '0) || (r_gx == '0);
        o_status.div_done = (r_cnt == SW'(MW));
    end

    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_cmp_sign = r_cmp;
endmodule

// ----- rtl/rau_ctrl.sv -----
// Controller: sequences load, multiply, gcd, the two divisions and result hand-off.
`timescale 1ns / 1ps
module rau_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_fire,
    input  logic              i_out_free,
    input  rau_pkg::t_status  i_status,
    output rau_pkg::t_cmd     o_cmd,
    output logic              o_busy,
    output logic              o_done
);
    rau_pkg::t_state r_state, n_state;
    logic r_fdone, n_fdone;   // gcd operands loaded, stepping may start

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::ST_IDLE;
            r_fdone <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fdone <= n_fdone;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fdone = 1'b0;
        o_cmd = '0;
        o_done = 1'b0;
        case (r_state)
            rau_pkg::ST_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state = rau_pkg::ST_MUL;
                end
            end
            rau_pkg::ST_MUL: n_state = rau_pkg::ST_FORM;
            rau_pkg::ST_FORM: begin
                o_cmd.form = 1'b1;
                n_state = i_status.reduce ? rau_pkg::ST_GCD : rau_pkg::ST_DONE;
            end
            rau_pkg::ST_GCD: begin
                if (!r_fdone) begin
                    o_cmd.gcd_init = 1'b1;
                    n_fdone = 1'b1;
                end else if (!i_status.gcd_done) begin
                    o_cmd.gcd_step = 1'b1;
                    n_fdone = 1'b1;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state = rau_pkg::ST_DIVN;
                end
            end
            rau_pkg::ST_DIVN: begin
                if (!i_status.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else begin
                    o_cmd.div_init = 1'b1;
                    o_cmd.div_sel_den = 1'b1;
                    n_state = rau_pkg::ST_DIVD;
                end
            end
            rau_pkg::ST_DIVD: begin
                if (!i_status.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else begin
                    n_state = rau_pkg::ST_DONE;
                end
            end
            rau_pkg::ST_DONE: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    o_done = 1'b1;
                    n_state = rau_pkg::ST_IDLE;
                end
            end
            default: n_state = rau_pkg::ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != rau_pkg::ST_IDLE);

    // division only starts once the gcd operands have been loaded and run
    a_div_after_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rau_pkg::ST_GCD && n_state == rau_pkg::ST_DIVN) |-> r_fdone)
        else $error("division started before gcd");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == rau_pkg::ST_IDLE))
        else $error("load outside idle");
    a_finish_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == rau_pkg::ST_IDLE))
        else $error("finish did not return to idle");
endmodule
